// File: src/eitp_pkg.sv
// Shared types and constants for the Ethernet/IPv4/TCP header parser.
package eitp_pkg;

    // Frame header positions and codes
    localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
    localparam logic [8:0]  IPV4_MIN_LEN   = 9'd34;
    localparam logic [8:0]  PROTO_END_LEN  = 9'd24;
    localparam logic [7:0]  TCP_DOFF_REL   = 8'd12;
    localparam logic [7:0]  TCP_NEED_REL   = 8'd13;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;

    // Frame record queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Raw header bytes of one finished frame
    typedef struct packed {
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] ethertype;
        logic [3:0]  ihl;
        logic [15:0] total_len;
        logic [7:0]  proto;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [3:0]  doff;
        logic [8:0]  frame_len;
    } frame_rec_t;

    // Summary flags of one frame
    typedef struct packed {
        logic short_frame;
        logic is_tcp;
        logic is_ipv4;
    } sum_flags_t;

endpackage

// File: src/eitp_front.sv
// Front end: accepts frame bytes and captures header fields by byte position.
module eitp_front import eitp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    output logic       rec_push,
    output frame_rec_t rec
);

    logic [7:0]  pos_reg;
    logic [47:0] dst_mac_reg, dst_mac_next;
    logic [47:0] src_mac_reg, src_mac_next;
    logic [15:0] ethertype_reg, ethertype_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [15:0] total_len_reg, total_len_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_ip_reg, src_ip_next;
    logic [31:0] dst_ip_reg, dst_ip_next;
    logic [15:0] src_port_reg, src_port_next;
    logic [15:0] dst_port_reg, dst_port_next;
    logic [3:0]  doff_reg, doff_next;

    logic        accept;
    logic [7:0]  tcp_start;
    logic [7:0]  rel;

    assign accept = s_tvalid && s_tready;

    // Fixed-position captures
    always_comb begin
        logic [2:0] lane6;
        logic [1:0] lane4;
        dst_mac_next   = dst_mac_reg;
        src_mac_next   = src_mac_reg;
        ethertype_next = ethertype_reg;
        ihl_next       = ihl_reg;
        total_len_next = total_len_reg;
        proto_next     = proto_reg;
        src_ip_next    = src_ip_reg;
        dst_ip_next    = dst_ip_reg;
        lane6          = '0;
        lane4          = '0;
        case (pos_reg) inside
            [8'd0:8'd5]: begin
                lane6 = 3'd5 - pos_reg[2:0];
                dst_mac_next[{lane6, 3'b000} +: 8] = s_tdata;
            end
            [8'd6:8'd11]: begin
                lane6 = 3'(4'd11 - pos_reg[3:0]);
                src_mac_next[{lane6, 3'b000} +: 8] = s_tdata;
            end
            8'd12: ethertype_next[15:8] = s_tdata;
            8'd13: ethertype_next[7:0]  = s_tdata;
            8'd14: ihl_next = s_tdata[3:0];
            8'd16: total_len_next[15:8] = s_tdata;
            8'd17: total_len_next[7:0]  = s_tdata;
            8'd23: proto_next = s_tdata;
            [8'd26:8'd29]: begin
                lane4 = 2'(5'd29 - pos_reg[4:0]);
                src_ip_next[{lane4, 3'b000} +: 8] = s_tdata;
            end
            [8'd30:8'd33]: begin
                lane4 = 2'(6'd33 - pos_reg[5:0]);
                dst_ip_next[{lane4, 3'b000} +: 8] = s_tdata;
            end
            default: ;
        endcase
    end

    // TCP header captures, placed by the IHL (the IHL byte itself counts at once)
    assign tcp_start = ETH_HDR_LEN + {2'b00, ihl_next, 2'b00};
    assign rel       = pos_reg - tcp_start;

    always_comb begin
        src_port_next = src_port_reg;
        dst_port_next = dst_port_reg;
        doff_next     = doff_reg;
        if (pos_reg >= tcp_start) begin
            case (rel)
                8'd0:         src_port_next[15:8] = s_tdata;
                8'd1:         src_port_next[7:0]  = s_tdata;
                8'd2:         dst_port_next[15:8] = s_tdata;
                8'd3:         dst_port_next[7:0]  = s_tdata;
                TCP_DOFF_REL: doff_next = s_tdata[7:4];
                default: ;
            endcase
        end
    end

    // Finished frame record, including the last byte
    assign rec_push = accept && s_tlast;
    always_comb begin
        rec.dst_mac   = dst_mac_next;
        rec.src_mac   = src_mac_next;
        rec.ethertype = ethertype_next;
        rec.ihl       = ihl_next;
        rec.total_len = total_len_next;
        rec.proto     = proto_next;
        rec.src_ip    = src_ip_next;
        rec.dst_ip    = dst_ip_next;
        rec.src_port  = src_port_next;
        rec.dst_port  = dst_port_next;
        rec.doff      = doff_next;
        rec.frame_len = {1'b0, pos_reg} + 9'd1;
    end

    // Capture registers; cleared at reset and after each frame
    always_ff @(posedge aclk) begin
        if (!aresetn || rec_push) begin
            pos_reg       <= '0;
            dst_mac_reg   <= '0;
            src_mac_reg   <= '0;
            ethertype_reg <= '0;
            ihl_reg       <= '0;
            total_len_reg <= '0;
            proto_reg     <= '0;
            src_ip_reg    <= '0;
            dst_ip_reg    <= '0;
            src_port_reg  <= '0;
            dst_port_reg  <= '0;
            doff_reg      <= '0;
        end else if (accept) begin
            if (pos_reg != 8'hFF) begin
                pos_reg <= pos_reg + 8'd1;
            end
            dst_mac_reg   <= dst_mac_next;
            src_mac_reg   <= src_mac_next;
            ethertype_reg <= ethertype_next;
            ihl_reg       <= ihl_next;
            total_len_reg <= total_len_next;
            proto_reg     <= proto_next;
            src_ip_reg    <= src_ip_next;
            dst_ip_reg    <= dst_ip_next;
            src_port_reg  <= src_port_next;
            dst_port_reg  <= dst_port_next;
            doff_reg      <= doff_next;
        end
    end

endmodule

// File: src/eitp_queue.sv
// Short queue of finished frame records between front and back.
module eitp_queue import eitp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  frame_rec_t push_rec,
    input  logic       pop,
    output logic       full,
    output logic       nempty,
    output frame_rec_t head_rec
);

    frame_rec_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign nempty   = (count_reg != '0);
    assign head_rec = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nempty;

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/eitp_back.sv
// Back end: turns a frame record into the summary and holds it for the sink.
module eitp_back import eitp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         rec_valid,
    input  frame_rec_t   rec,
    output logic         rec_pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [215:0] m_tdata,
    output sum_flags_t   m_tuser
);

    logic         m_valid_reg;
    logic [215:0] m_data_reg, m_data_next;
    sum_flags_t   m_user_reg, m_user_next;

    logic         ipv4;
    logic         tcp;
    logic [7:0]   tcp_start;
    logic [7:0]   tcp_need;
    logic [7:0]   needed;
    logic [7:0]   pl_offset;
    logic [15:0]  pl_length;

    // Flags and derived lengths
    always_comb begin
        ipv4      = (rec.frame_len >= {1'b0, ETH_HDR_LEN}) && (rec.ethertype == ETHERTYPE_IPV4);
        tcp       = ipv4 && (rec.frame_len >= PROTO_END_LEN) && (rec.proto == IP_PROTO_TCP);
        tcp_start = ETH_HDR_LEN + {2'b00, rec.ihl, 2'b00};
        tcp_need  = tcp_start + TCP_NEED_REL;
        needed    = ETH_HDR_LEN;
        if (ipv4) begin
            needed = IPV4_MIN_LEN[7:0];
        end
        if (tcp && (tcp_need > needed)) begin
            needed = tcp_need;
        end
        pl_offset = tcp_start + {2'b00, rec.doff, 2'b00};
        pl_length = rec.total_len - {10'd0, rec.ihl, 2'b00} - {10'd0, rec.doff, 2'b00};
    end

    // Summary packing
    always_comb begin
        m_data_next = {
            tcp  ? pl_length    : 16'd0,
            tcp  ? pl_offset    : 8'd0,
            tcp  ? rec.src_port : 16'd0,
            tcp  ? rec.dst_port : 16'd0,
            ipv4 ? rec.src_ip   : 32'd0,
            ipv4 ? rec.dst_ip   : 32'd0,
            rec.src_mac,
            rec.dst_mac
        };
        m_user_next.is_ipv4     = ipv4;
        m_user_next.is_tcp      = tcp;
        m_user_next.short_frame = (rec.frame_len < {1'b0, needed});
    end

    // Output register: loads when empty or being drained
    assign rec_pop = rec_valid && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rec_pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_pop) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: src/eth_ipv4_tcp_header_parser.sv
// A finished frame's record passes through the record queue and then the output register to the m_ side.
// Throughput: one byte per cycle while s_tready is high; at most one summary per cycle, set by the output register.
// A two-entry record queue lets bytes keep flowing while a summary waits for m_tready.
// s_tready drops only while the queue is full.
// Reset (aresetn low, synchronous) empties the queue, drops m_tvalid and clears all captures.
module eth_ipv4_tcp_header_parser import eitp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [47:0] dst_mac_address, [95:48] src_mac_address, [127:96] dst_ip_address,
    // [159:128] src_ip_address, [175:160] dst_port, [191:176] src_port,
    // [199:192] payload_offset, [215:200] payload_length
    output logic [215:0] m_tdata,
    output sum_flags_t   m_tuser    // [0] is_ipv4, [1] is_tcp, [2] short_frame
);

    logic       rec_push;
    frame_rec_t rec_in;
    logic       q_full;
    logic       q_nempty;
    frame_rec_t q_head;
    logic       q_pop;

    assign s_tready = !q_full;

    eitp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .rec_push (rec_push),
        .rec      (rec_in)
    );

    eitp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (rec_push),
        .push_rec (rec_in),
        .pop      (q_pop),
        .full     (q_full),
        .nempty   (q_nempty),
        .head_rec (q_head)
    );

    eitp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (q_nempty),
        .rec       (q_head),
        .rec_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: tb/eth_ipv4_tcp_header_parser_test.sv
// Self-checking testbench for the Ethernet/IPv4/TCP header parser.
`timescale 1ns / 1ps

module eth_ipv4_tcp_header_parser_test;
    import eitp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    // One frame summary as the block reports it
    typedef struct {
        logic        is_ipv4;
        logic        is_tcp;
        logic        short_frame;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [31:0] dst_ip;
        logic [31:0] src_ip;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [7:0]  payload_offset;
        logic [15:0] payload_length;
    } frame_summary_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [215:0] m_tdata;
    sum_flags_t   m_tuser;

    eth_ipv4_tcp_header_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // Header capture state of the frame in flight
    logic [7:0]  frame_pos = '0;
    logic [47:0] cap_dst_mac = '0;
    logic [47:0] cap_src_mac = '0;
    logic [15:0] cap_ethertype = '0;
    logic [3:0]  cap_ihl = '0;
    logic [15:0] cap_total_len = '0;
    logic [7:0]  cap_proto = '0;
    logic [31:0] cap_src_ip = '0;
    logic [31:0] cap_dst_ip = '0;
    logic [15:0] cap_src_port = '0;
    logic [15:0] cap_dst_port = '0;
    logic [3:0]  cap_doff = '0;

    frame_summary_t pending_summaries[$];
    logic [7:0]     frame_buf[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int bytes_sent = 0;
    int mismatches = 0;
    int cycle_count = 0;

    // Capture one byte by position; on the last byte build the summary and clear
    task automatic absorb_byte(input logic [7:0] b, input logic is_last,
                               output bit done, output frame_summary_t sum);
        int p;
        int tcp_start;
        int rel;
        int len;
        int needed;
        bit ipv4;
        bit tcp;
        p = frame_pos;
        done = 0;
        sum = '{default: '0};
        if (p < 6)
            cap_dst_mac[8 * (5 - p) +: 8] = b;
        else if (p < 12)
            cap_src_mac[8 * (11 - p) +: 8] = b;
        else if (p == 12)
            cap_ethertype[15:8] = b;
        else if (p == 13)
            cap_ethertype[7:0] = b;
        else if (p == 14)
            cap_ihl = b[3:0];
        else if (p == 16)
            cap_total_len[15:8] = b;
        else if (p == 17)
            cap_total_len[7:0] = b;
        else if (p == 23)
            cap_proto = b;
        else if (p >= 26 && p < 30)
            cap_src_ip[8 * (29 - p) +: 8] = b;
        else if (p >= 30 && p < 34)
            cap_dst_ip[8 * (33 - p) +: 8] = b;

        // TCP header follows the IPv4 header; a new IHL byte counts at once
        tcp_start = ETH_HDR_LEN + 4 * cap_ihl;
        if (p >= tcp_start) begin
            rel = p - tcp_start;
            case (rel)
                0: cap_src_port[15:8] = b;
                1: cap_src_port[7:0] = b;
                2: cap_dst_port[15:8] = b;
                3: cap_dst_port[7:0] = b;
                TCP_DOFF_REL: cap_doff = b[7:4];
                default: ;
            endcase
        end

        if (!is_last) begin
            if (frame_pos != 8'd255)
                frame_pos = frame_pos + 8'd1;
            return;
        end

        len = p + 1;
        ipv4 = len >= ETH_HDR_LEN && cap_ethertype == ETHERTYPE_IPV4;
        tcp = ipv4 && len >= PROTO_END_LEN && cap_proto == IP_PROTO_TCP;
        needed = ETH_HDR_LEN;
        if (ipv4)
            needed = IPV4_MIN_LEN;
        if (tcp && tcp_start + TCP_NEED_REL > needed)
            needed = tcp_start + TCP_NEED_REL;

        done = 1;
        sum.is_ipv4 = ipv4;
        sum.is_tcp = tcp;
        sum.short_frame = len < needed;
        sum.dst_mac = cap_dst_mac;
        sum.src_mac = cap_src_mac;
        sum.dst_ip = ipv4 ? cap_dst_ip : '0;
        sum.src_ip = ipv4 ? cap_src_ip : '0;
        sum.dst_port = tcp ? cap_dst_port : '0;
        sum.src_port = tcp ? cap_src_port : '0;
        sum.payload_offset = tcp ? 8'(tcp_start + 4 * cap_doff) : '0;
        sum.payload_length = tcp ? 16'(cap_total_len - 4 * cap_ihl - 4 * cap_doff) : '0;

        frame_pos = '0;
        cap_dst_mac = '0;
        cap_src_mac = '0;
        cap_ethertype = '0;
        cap_ihl = '0;
        cap_total_len = '0;
        cap_proto = '0;
        cap_src_ip = '0;
        cap_dst_ip = '0;
        cap_src_port = '0;
        cap_dst_port = '0;
        cap_doff = '0;
    endtask

    // Offer one byte, with random idle cycles ahead of it, until it is taken
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        frame_summary_t sum;
        bit done;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tlast <= is_last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        absorb_byte(value, is_last, done, sum);
        if (done)
            pending_summaries.push_back(sum);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[i])
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        stop_sending();
        while (pending_summaries.size() != 0)
            @(posedge aclk);
    endtask

    function automatic void set_frame_byte(input int pos, input logic [7:0] v);
        if (pos < frame_buf.size())
            frame_buf[pos] = v;
    endfunction

    // Fill the frame buffer; fill < 0 means random filler bytes
    function automatic void build_frame(input int len, input logic [15:0] etype,
                                        input logic [7:0] ver_ihl, input logic [7:0] proto,
                                        input logic [7:0] doff_byte, input int fill);
        int tcp_pos;
        frame_buf.delete();
        for (int i = 0; i < len; i++)
            frame_buf.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        tcp_pos = 14 + 4 * ver_ihl[3:0];
        set_frame_byte(12, etype[15:8]);
        set_frame_byte(13, etype[7:0]);
        set_frame_byte(14, ver_ihl);
        set_frame_byte(23, proto);
        set_frame_byte(tcp_pos + 12, doff_byte);
    endfunction

    // Extremes, every flag combination, overlapping headers, short and long frames
    task automatic test_directed_frames();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        build_frame(1, 16'h0000, 8'h00, 8'h00, 8'h00, 255);
        send_frame();
        build_frame(13, ETHERTYPE_IPV4, 8'h45, IP_PROTO_TCP, 8'h50, -1);
        send_frame();
        build_frame(14, ETHERTYPE_IPV4, 8'h45, IP_PROTO_TCP, 8'h50, 0);
        send_frame();
        build_frame(14, 16'hFFFF, 8'h45, IP_PROTO_TCP, 8'h50, 0);
        send_frame();
        build_frame(24, ETHERTYPE_IPV4, 8'h45, IP_PROTO_TCP, 8'h50, 255);
        send_frame();
        build_frame(54, ETHERTYPE_IPV4, 8'h45, IP_PROTO_TCP, 8'h50, 255);
        send_frame();
        // IHL zero: the TCP ports start on the IHL byte itself
        build_frame(40, ETHERTYPE_IPV4, 8'h40, IP_PROTO_TCP, 8'hF0, -1);
        send_frame();
        build_frame(34, ETHERTYPE_IPV4, 8'h42, IP_PROTO_TCP, 8'h30, -1);
        send_frame();
        build_frame(90, ETHERTYPE_IPV4, 8'hFF, IP_PROTO_TCP, 8'hFF, 255);
        send_frame();
        build_frame(40, ETHERTYPE_IPV4, 8'h45, 8'd17, 8'h50, -1);
        send_frame();
        build_frame(20, 16'h86DD, 8'h45, IP_PROTO_TCP, 8'h50, -1);
        send_frame();
        // Position counter saturates well past every capture
        build_frame(260, ETHERTYPE_IPV4, 8'h45, IP_PROTO_TCP, 8'h50, -1);
        send_frame();
        wait_drained();
    endtask

    task automatic build_random_frame();
        logic [15:0] etype;
        logic [7:0]  ver_ihl;
        logic [7:0]  proto;
        logic [7:0]  doff_byte;
        int          full;
        int          len;
        int          fill;
        int          pick;
        etype = ($urandom_range(9) < 7) ? ETHERTYPE_IPV4 : 16'($urandom);
        ver_ihl = ($urandom_range(9) < 6) ? 8'h45 : 8'($urandom);
        proto = ($urandom_range(9) < 8) ? IP_PROTO_TCP : 8'($urandom);
        doff_byte = ($urandom_range(1) == 0) ? 8'($urandom) : {4'd5, 4'($urandom)};
        pick = $urandom_range(19);
        fill = (pick == 0) ? 0 : (pick == 1) ? 255 : -1;
        full = 14 + 4 * ver_ihl[3:0] + 13;
        if (full < 34)
            full = 34;
        pick = $urandom_range(39);
        if (pick < 5)
            len = $urandom_range(1, full - 1);
        else if (pick == 5)
            len = $urandom_range(256, 300);
        else
            len = full + $urandom_range(0, 24);
        build_frame(len, etype, ver_ihl, proto, doff_byte, fill);
        // Half the frames carry a consistent IPv4 total length
        if ($urandom_range(1) == 0) begin
            set_frame_byte(16, 8'((len - 14) >> 8));
            set_frame_byte(17, 8'(len - 14));
        end
    endtask

    task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                      input int byte_target);
        int first;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        first = bytes_sent;
        while (bytes_sent - first < byte_target) begin
            build_random_frame();
            send_frame();
        end
        wait_drained();
    endtask

    // Receiver holds off while tiny frames keep coming, so the input must stall
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 300;
        for (int i = 0; i < 40; i++) begin
            build_frame($urandom_range(1, 3), 16'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), -1);
            send_frame();
        end
        wait_drained();
    endtask

    // Sender waits for each summary before the next frame
    task automatic test_drain_pause();
        send_idle_pct = 20;
        recv_stall_pct = 38;
        for (int i = 0; i < 3; i++) begin
            build_random_frame();
            send_frame();
            wait_drained();
        end
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // Compare each taken summary with the oldest expectation
    always @(posedge aclk) begin
        frame_summary_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_summaries.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected summary: tdata %0h tuser %0h", m_tdata, m_tuser);
            end else begin
                want = pending_summaries.pop_front();
                check_field("is_ipv4", want.is_ipv4, m_tuser.is_ipv4);
                check_field("is_tcp", want.is_tcp, m_tuser.is_tcp);
                check_field("short_frame", want.short_frame, m_tuser.short_frame);
                check_field("dst_mac_address", want.dst_mac, m_tdata[47:0]);
                check_field("src_mac_address", want.src_mac, m_tdata[95:48]);
                check_field("dst_ip_address", want.dst_ip, m_tdata[127:96]);
                check_field("src_ip_address", want.src_ip, m_tdata[159:128]);
                check_field("dst_port", want.dst_port, m_tdata[175:160]);
                check_field("src_port", want.src_port, m_tdata[191:176]);
                check_field("payload_offset", want.payload_offset, m_tdata[199:192]);
                check_field("payload_length", want.payload_length, m_tdata[215:200]);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_frames();
        test_random_frames(0, 0, 40);
        test_random_frames(58, 0, 40);
        test_random_frames(0, 58, 40);
        test_random_frames(38, 38, 40);
        test_output_backpressure();
        test_drain_pause();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_summaries.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
src/eitp_pkg.sv
src/eitp_front.sv
src/eitp_queue.sv
src/eitp_back.sv
src/eth_ipv4_tcp_header_parser.sv
tb/eth_ipv4_tcp_header_parser_test.sv
